### hdl/assert_macros.svh
// assertion helpers for the round unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/aesr_pkg.sv
// ----------------------------------------------------------------------------
// aesr_pkg
// opcodes, s-box tables and gf helpers for the round unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package aesr_pkg;

  localparam logic [2:0] OP_ADD_KEY   = 3'd0;
  localparam logic [2:0] OP_FWD_ROUND = 3'd1;
  localparam logic [2:0] OP_FWD_FINAL = 3'd2;
  localparam logic [2:0] OP_INV_ROUND = 3'd3;
  localparam logic [2:0] OP_INV_FINAL = 3'd4;

  typedef struct packed {
    logic fwd;
    logic inv;
    logic mix;
  } ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

### hdl/aesr_lane.sv
// ----------------------------------------------------------------------------
// aesr_lane
// one column lane: byte substitution, key addition and column mixing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aesr_lane (
  input  wire aesr_pkg::ctrl_t ctrl_i,
  input  wire logic [31:0]     col_i,
  input  wire logic [31:0]     key_i,
  output logic [31:0]          col_o
);

  logic [7:0] b   [4];
  logic [7:0] s   [4];
  logic [7:0] x2  [4];
  logic [7:0] x4  [4];
  logic [7:0] x8  [4];
  logic [7:0] m   [4];
  logic [7:0] m9  [4];
  logic [7:0] m11 [4];
  logic [7:0] m13 [4];
  logic [7:0] m14 [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      b[r] = col_i[31-8*r -: 8];
      if (ctrl_i.fwd) begin
        s[r] = aesr_pkg::SBOX[b[r]];
      end else if (ctrl_i.inv) begin
        s[r] = aesr_pkg::INV_SBOX[b[r]];
      end else begin
        s[r] = b[r];
      end
    end
  end

  // forward mixing comes before the key, inverse mixing after it
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      m[r] = ctrl_i.inv ? (s[r] ^ key_i[31-8*r -: 8]) : s[r];
      x2[r] = aesr_pkg::xtime(m[r]);
      x4[r] = aesr_pkg::xtime(x2[r]);
      x8[r] = aesr_pkg::xtime(x4[r]);
      m9[r]  = x8[r] ^ m[r];
      m11[r] = x8[r] ^ x2[r] ^ m[r];
      m13[r] = x8[r] ^ x4[r] ^ m[r];
      m14[r] = x8[r] ^ x4[r] ^ x2[r];
    end
    for (int r = 0; r < 4; r++) begin
      if (ctrl_i.mix && ctrl_i.fwd) begin
        col_o[31-8*r -: 8] = x2[r] ^ x2[(r+1)%4] ^ m[(r+1)%4] ^ m[(r+2)%4] ^ m[(r+3)%4]
                             ^ key_i[31-8*r -: 8];
      end else if (ctrl_i.mix) begin
        col_o[31-8*r -: 8] = m14[r] ^ m11[(r+1)%4] ^ m13[(r+2)%4] ^ m9[(r+3)%4];
      end else if (ctrl_i.inv) begin
        col_o[31-8*r -: 8] = m[r];
      end else begin
        col_o[31-8*r -: 8] = m[r] ^ key_i[31-8*r -: 8];
      end
    end
  end

endmodule
`default_nettype wire

### hdl/aes_round_unit.sv
// ----------------------------------------------------------------------------
// aes_round_unit
// one aes-128 round per request, four column lanes and a registered output
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  in      | in_valid_i, in_stall_o, opcode_i, state/key    | request in
//  out     | out_valid_o, out_stall_i, result_hi/lo_o       | result out
//
//  one request per cycle while in_stall_o is low; the result is registered.
//  the four lanes and the row shift run in the single input-to-register stage.
//  a two-entry buffer (output register plus skid) takes one more request while
//  the output is stalled; the input stalls once the skid is full.
//  reset empties both entries.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module aes_round_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [63:0] state_hi_i,
  input  wire logic [63:0] state_lo_i,
  input  wire logic [63:0] key_hi_i,
  input  wire logic [63:0] key_lo_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      result_hi_o,
  output logic [63:0]      result_lo_o
);

  aesr_pkg::ctrl_t ctrl;
  logic [7:0]   sb [16];
  logic [7:0]   sh [16];
  logic [127:0] st, ky, res;
  logic [127:0] out_q, out_d, skid_q, skid_d;
  logic         ov_q, ov_d, sv_q, sv_d;
  logic         in_acc, out_acc;

  always_comb begin
    ctrl = '0;
    unique case (opcode_i)
      aesr_pkg::OP_FWD_ROUND: ctrl = '{fwd: 1'b1, inv: 1'b0, mix: 1'b1};
      aesr_pkg::OP_FWD_FINAL: ctrl = '{fwd: 1'b1, inv: 1'b0, mix: 1'b0};
      aesr_pkg::OP_INV_ROUND: ctrl = '{fwd: 1'b0, inv: 1'b1, mix: 1'b1};
      aesr_pkg::OP_INV_FINAL: ctrl = '{fwd: 1'b0, inv: 1'b1, mix: 1'b0};
      default:                ctrl = '0;
    endcase
  end

  assign st = {state_hi_i, state_lo_i};
  assign ky = {key_hi_i, key_lo_i};

  // row shift ahead of the lanes; substitution commutes with it
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[i] = st[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctrl.fwd) begin
          sh[4*c+r] = sb[4*((c+r)%4)+r];
        end else if (ctrl.inv) begin
          sh[4*c+r] = sb[4*((c+4-r)%4)+r];
        end else begin
          sh[4*c+r] = sb[4*c+r];
        end
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    aesr_lane u_lane (
      .ctrl_i (ctrl),
      .col_i  ({sh[4*c], sh[4*c+1], sh[4*c+2], sh[4*c+3]}),
      .key_i  (ky[127-32*c -: 32]),
      .col_o  (res[127-32*c -: 32])
    );
  end

  assign in_stall_o = sv_q;
  assign in_acc     = in_valid_i && !sv_q;
  assign out_acc    = ov_q && !out_stall_i;

  always_comb begin
    out_d  = out_q;
    ov_d   = ov_q;
    skid_d = skid_q;
    sv_d   = sv_q;
    if (!ov_q || out_acc) begin
      if (sv_q) begin
        out_d = skid_q;
        ov_d  = 1'b1;
        sv_d  = 1'b0;
      end else begin
        out_d = res;
        ov_d  = in_acc;
      end
    end else if (in_acc) begin
      skid_d = res;
      sv_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = ov_q;
  assign result_hi_o = out_q[127:64];
  assign result_lo_o = out_q[63:0];

  `ASSERT_IMPL(a_skid_needs_out, clk_i, rst_ni, sv_q, ov_q)
  `ASSERT_NEXT(a_accept_gives_valid, clk_i, rst_ni, in_acc, ov_q)
  `ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, ov_q && out_stall_i, ov_q && $stable(out_q))

endmodule
`default_nettype wire
